[hdl/srfe_pkg.sv]
// srfe_pkg: shared types, constants and helpers for the satellite rc frame encoder
// no dependencies; imported by srfe_chan_mem, srfe_word_enc and the top level
package srfe_pkg;

    // default sizes handed to the top level parameters
    localparam int NUM_CHANNELS_DEF    = 12;
    localparam int WORDS_PER_FRAME_DEF = 7;

    // request kinds
    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_NO_PULSES = 1'b1;

    // protocol modes
    localparam logic [1:0] MODE_DSMX_11 = 2'd0;
    localparam logic [1:0] MODE_DSMX_22 = 2'd1;
    localparam logic [1:0] MODE_DSM2_11 = 2'd2;
    localparam logic [1:0] MODE_DSM2_22 = 2'd3;

    localparam int RAW_W  = 11;
    localparam int CHAN_W = 4;
    localparam int WORD_W = 16;

    // raw to microseconds: us = 988 +- round(|raw - 172| * 1024 / 1639)
    localparam int RAW_MID = 172;
    localparam int US_MID  = 988;
    localparam int US_MIN  = 903;
    localparam int US_MAX  = 2097;
    localparam int DIV1    = 3278;
    localparam int RND1    = 1639;
    localparam int SH1     = 34;

    // microseconds to counts: w = (d * scale + 583) / 1166
    localparam int SCALE_WIDE   = 2000;
    localparam int SCALE_NARROW = 1000;
    localparam int DIV2         = 1166;
    localparam int RND2         = 583;
    localparam int SH2          = 33;
    localparam int SAT_WIDE     = 2047;
    localparam int SAT_NARROW   = 1023;

    // reciprocals rounded up: exact floor division for 22-bit dividends
    localparam longint unsigned RECIP1 = ((64'd1 << SH1) + DIV1 - 1) / DIV1;
    localparam longint unsigned RECIP2 = ((64'd1 << SH2) + DIV2 - 1) / DIV2;

    localparam int DVD_W  = 22;
    localparam int RCP_W  = 23;
    localparam int PROD_W = DVD_W + RCP_W;

    typedef struct packed {
        logic              vld;
        logic [RAW_W-1:0]  raw;
        logic [CHAN_W-1:0] chan;
        logic              wide;
    } t_enc_req;

    typedef struct packed {
        logic              vld;
        logic [WORD_W-1:0] word;
    } t_enc_rsp;

    function automatic logic [7:0] proto_code(input logic [1:0] mode);
        logic [7:0] code;
        case (mode)
            MODE_DSMX_11: code = 8'hB2;
            MODE_DSMX_22: code = 8'hA2;
            MODE_DSM2_11: code = 8'h12;
            MODE_DSM2_22: code = 8'h01;
            default:      code = 8'hB2;
        endcase
        return code;
    endfunction

endpackage

[hdl/srfe_chan_mem.sv]
// srfe_chan_mem: current and last-sent channel value memories, registered reads with data out the cycle after i_rd_en
// entries read as zero until first written (per-entry valid bits); uses srfe_pkg
module srfe_chan_mem import srfe_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int AW           = $clog2(NUM_CHANNELS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_st_we,
    input  logic [AW-1:0]    i_st_addr,
    input  logic [RAW_W-1:0] i_st_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic             i_sw_we,
    input  logic [AW-1:0]    i_sw_addr,
    input  logic [RAW_W-1:0] i_sw_data,
    output logic [RAW_W-1:0] o_cur,
    output logic [RAW_W-1:0] o_sent
);

    logic [RAW_W-1:0]        r_cur_mem  [NUM_CHANNELS];
    logic [RAW_W-1:0]        r_sent_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_cur_vld;
    logic [NUM_CHANNELS-1:0] r_sent_vld;
    logic [RAW_W-1:0]        r_cur_q;
    logic [RAW_W-1:0]        r_sent_q;
    logic                    r_cur_qv;
    logic                    r_sent_qv;

    always_ff @(posedge i_clk) begin
        if (i_st_we) begin
            r_cur_mem[i_st_addr] <= i_st_data;
        end
        if (i_sw_we) begin
            r_sent_mem[i_sw_addr] <= i_sw_data;
        end
        if (i_rd_en) begin
            r_cur_q  <= r_cur_mem[i_rd_addr];
            r_sent_q <= r_sent_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld  <= '0;
            r_sent_vld <= '0;
            r_cur_qv   <= 1'b0;
            r_sent_qv  <= 1'b0;
        end else begin
            if (i_st_we) begin
                r_cur_vld[i_st_addr] <= 1'b1;
            end
            if (i_sw_we) begin
                r_sent_vld[i_sw_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_cur_qv  <= r_cur_vld[i_rd_addr];
                r_sent_qv <= r_sent_vld[i_rd_addr];
            end
        end
    end

    assign o_cur  = r_cur_qv  ? r_cur_q  : '0;
    assign o_sent = r_sent_qv ? r_sent_q : '0;

endmodule

[hdl/srfe_word_enc.sv]
// srfe_word_enc: four-stage pipeline turning a raw channel value into a frame word
// constant division by reciprocal multiply; uses srfe_pkg
module srfe_word_enc import srfe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_enc_req i_req,
    output t_enc_rsp o_rsp
);

    logic r_v1, r_v2, r_v3, r_v4;

    logic [10:0]       r_q1;
    logic              r_neg1;
    logic [CHAN_W-1:0] r_chan1, r_chan2, r_chan3;
    logic              r_wide1, r_wide2, r_wide3;
    logic [DVD_W-1:0]  r_y2;
    logic [11:0]       r_w3;
    logic [WORD_W-1:0] r_word;

    logic              w_neg;
    logic [RAW_W-1:0]  w_mag;
    logic [DVD_W-1:0]  w_x;
    logic [PROD_W-1:0] w_p1;
    logic [11:0]       w_us;
    logic [11:0]       w_us_c;
    logic [10:0]       w_d;
    logic [DVD_W-1:0]  w_y;
    logic [PROD_W-1:0] w_p2;
    logic [10:0]       w_wsat;

    // stage 1: |raw - 172| scaled, divided by 3278 with round half up
    always_comb begin
        w_neg = i_req.raw < RAW_W'(RAW_MID);
        w_mag = w_neg ? RAW_W'(RAW_MID) - i_req.raw : i_req.raw - RAW_W'(RAW_MID);
        w_x   = {w_mag, 11'd0} + DVD_W'(RND1);
        w_p1  = PROD_W'(w_x) * PROD_W'(RCP_W'(RECIP1));
    end

    // stage 2: microseconds, clamp, rescale numerator
    always_comb begin
        w_us   = r_neg1 ? 12'(US_MID) - 12'(r_q1) : 12'(US_MID) + 12'(r_q1);
        w_us_c = w_us;
        if (w_us < 12'(US_MIN)) begin
            w_us_c = 12'(US_MIN);
        end else if (w_us > 12'(US_MAX)) begin
            w_us_c = 12'(US_MAX);
        end
        w_d = 11'(w_us_c - 12'(US_MIN));
        w_y = DVD_W'(w_d) * (r_wide2 ? DVD_W'(SCALE_WIDE) : DVD_W'(SCALE_NARROW))
              + DVD_W'(RND2);
    end

    // stage 3: divide by 1166
    assign w_p2 = PROD_W'(r_y2) * PROD_W'(RCP_W'(RECIP2));

    // stage 4: saturate and place the channel index
    always_comb begin
        if (r_wide3) begin
            w_wsat = (r_w3 > 12'(SAT_WIDE)) ? 11'(SAT_WIDE) : r_w3[10:0];
        end else begin
            w_wsat = (r_w3 > 12'(SAT_NARROW)) ? 11'(SAT_NARROW) : r_w3[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_q1    <= w_p1[SH1+10:SH1];
        r_neg1  <= w_neg;
        r_chan1 <= i_req.chan;
        r_wide1 <= i_req.wide;

        r_y2    <= w_y;
        r_chan2 <= r_chan1;
        r_wide2 <= r_wide1;

        r_w3    <= w_p2[SH2+11:SH2];
        r_chan3 <= r_chan2;
        r_wide3 <= r_wide2;

        if (r_wide3) begin
            r_word <= {1'b0, r_chan3, w_wsat};
        end else begin
            r_word <= {2'b00, r_chan3, w_wsat[9:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_req.vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage 2 reads r_q1 and r_neg1 through w_us
    assign o_rsp.vld  = r_v4;
    assign o_rsp.word = r_word;

endmodule

[hdl/satellite_rc_frame_encoder_core.sv]
// store request: taken while idle, next request accepted the cycle after.
// tick request, unless skipped: a memory read and a compare per scanned channel, plus a
// wait for the encoder pipeline per channel sent, then 2 + 2 * words bytes at one per
// cycle while the output is not stalled.
// sync active-low reset clears control state and the channel valid bits, so every
// stored and sent channel value reads as zero until written; no clearing pass.
module satellite_rc_frame_encoder_core import srfe_pkg::*; #(
    parameter int NUM_CHANNELS    = NUM_CHANNELS_DEF,
    parameter int WORDS_PER_FRAME = WORDS_PER_FRAME_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_kind,
    input  logic [CHAN_W-1:0]    i_channel_index,
    input  logic [RAW_W-1:0]     i_channel_value,
    input  logic                 i_frame_missed,
    input  logic                 i_in_failsafe,
    input  logic                 i_link_connected,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_byte
);

    localparam int AW  = $clog2(NUM_CHANNELS);
    localparam int CCW = $clog2(NUM_CHANNELS + 1);
    localparam int CNW = $clog2(WORDS_PER_FRAME + 1);
    localparam int WIW = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
    localparam int SW  = 6;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_READ     = 5'b00010,
        ST_CHECK    = 5'b00100,
        ST_ENC_WAIT = 5'b01000,
        ST_EMIT     = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        SEG_FADE  = 2'd0,
        SEG_PROTO = 2'd1,
        SEG_HI    = 2'd2,
        SEG_LO    = 2'd3
    } t_seg;

    t_state r_state, n_state;
    logic [1:0]     r_mode;
    logic           r_fs_np;
    logic           r_started, n_started;
    logic [7:0]     r_fade, n_fade;
    logic [AW-1:0]  r_ptr, n_ptr;
    logic [CCW-1:0] r_cc, n_cc;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic [CNW-1:0] r_wi, n_wi;
    t_seg           r_seg, n_seg;
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_out_byte, n_out_byte;
    logic           r_out_last, n_out_last;
    logic [WORD_W-1:0] r_wbuf [WORDS_PER_FRAME];

    logic             w_in_acc;
    logic             w_st_we;
    logic             w_skip;
    logic [RAW_W-1:0] w_cur;
    logic [RAW_W-1:0] w_sent;
    logic             w_forced;
    logic             w_take;
    logic             w_load;
    logic [CCW-1:0]   w_cc_inc;
    logic [CNW-1:0]   w_cnt_inc;
    logic [CNW-1:0]   w_wi_inc;
    logic [AW-1:0]    w_ptr_inc;
    logic [WORD_W-1:0] w_word_rd;
    t_enc_req         w_req;
    t_enc_rsp         w_rsp;

    srfe_chan_mem #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .AW           (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_st_we   (w_st_we),
        .i_st_addr (i_channel_index[AW-1:0]),
        .i_st_data (i_channel_value),
        .i_rd_en   (r_state == ST_READ),
        .i_rd_addr (r_ptr),
        .i_sw_we   (w_req.vld),
        .i_sw_addr (r_ptr),
        .i_sw_data (w_cur),
        .o_cur     (w_cur),
        .o_sent    (w_sent)
    );

    srfe_word_enc u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_in_acc = i_in_valid && (r_state == ST_IDLE);
    assign w_st_we  = w_in_acc && (i_kind == KIND_STORE)
                      && (32'(i_channel_index) < NUM_CHANNELS);
    assign w_skip   = (i_in_failsafe && r_fs_np) || (!r_started && !i_link_connected)
                      || i_frame_missed;

    // fill the frame once the words still owed equal the channels left to scan
    assign w_forced = (SW'(r_cnt) + SW'(NUM_CHANNELS)) == (SW'(r_cc) + SW'(WORDS_PER_FRAME));
    assign w_take   = (w_cur != w_sent) || w_forced;

    assign w_req.vld  = (r_state == ST_CHECK) && w_take;
    assign w_req.raw  = w_cur;
    assign w_req.chan = CHAN_W'(r_ptr);
    assign w_req.wide = (r_mode != MODE_DSM2_22);

    assign w_load    = !r_out_valid || !i_out_stall;
    assign w_cc_inc  = r_cc + CCW'(1);
    assign w_cnt_inc = r_cnt + CNW'(1);
    assign w_wi_inc  = r_wi + CNW'(1);
    assign w_ptr_inc = (r_ptr == AW'(NUM_CHANNELS - 1)) ? '0 : r_ptr + AW'(1);
    assign w_word_rd = r_wbuf[r_wi[WIW-1:0]];

    always_comb begin
        n_state     = r_state;
        n_started   = r_started;
        n_fade      = r_fade;
        n_ptr       = r_ptr;
        n_cc        = r_cc;
        n_cnt       = r_cnt;
        n_wi        = r_wi;
        n_seg       = r_seg;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_kind == KIND_TICK)) begin
                    if (w_skip) begin
                        if (r_started && (r_fade != 8'hFF)) begin
                            n_fade = r_fade + 8'd1;
                        end
                    end else begin
                        n_started = 1'b1;
                        n_cc      = '0;
                        n_cnt     = '0;
                        n_state   = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_ptr = w_ptr_inc;
                n_cc  = w_cc_inc;
                if (w_take) begin
                    n_state = ST_ENC_WAIT;
                end else if ((w_cc_inc < CCW'(NUM_CHANNELS))
                             && (r_cnt < CNW'(WORDS_PER_FRAME))) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_EMIT;
                    n_seg   = SEG_FADE;
                end
            end
            ST_ENC_WAIT: begin
                if (w_rsp.vld) begin
                    n_cnt = w_cnt_inc;
                    if ((r_cc < CCW'(NUM_CHANNELS))
                        && (w_cnt_inc < CNW'(WORDS_PER_FRAME))) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_EMIT;
                        n_seg   = SEG_FADE;
                    end
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b0;
                    case (r_seg)
                        SEG_FADE: begin
                            n_out_byte = r_fade;
                            n_seg      = SEG_PROTO;
                        end
                        SEG_PROTO: begin
                            n_out_byte = proto_code(r_mode);
                            n_wi       = '0;
                            n_seg      = SEG_HI;
                            if (r_cnt == '0) begin
                                n_out_last = 1'b1;
                                n_state    = ST_IDLE;
                            end
                        end
                        SEG_HI: begin
                            n_out_byte = w_word_rd[15:8];
                            n_seg      = SEG_LO;
                        end
                        SEG_LO: begin
                            n_out_byte = w_word_rd[7:0];
                            n_wi       = w_wi_inc;
                            n_seg      = SEG_HI;
                            if (w_wi_inc == r_cnt) begin
                                n_out_last = 1'b1;
                                n_state    = ST_IDLE;
                            end
                        end
                        default: begin
                            n_seg = SEG_FADE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_DSMX_11;
            r_fs_np     <= 1'b0;
            r_started   <= 1'b0;
            r_fade      <= '0;
            r_ptr       <= '0;
            r_cc        <= '0;
            r_cnt       <= '0;
            r_wi        <= '0;
            r_seg       <= SEG_FADE;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_fade      <= n_fade;
            r_ptr       <= n_ptr;
            r_cc        <= n_cc;
            r_cnt       <= n_cnt;
            r_wi        <= n_wi;
            r_seg       <= n_seg;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROTO_MODE:   r_mode  <= i_cfg_wdata;
                    CFG_FS_NO_PULSES: r_fs_np <= i_cfg_wdata[0];
                    default:          r_mode  <= r_mode;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        if ((r_state == ST_ENC_WAIT) && w_rsp.vld) begin
            r_wbuf[r_cnt[WIW-1:0]] <= w_rsp.word;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ptr) < NUM_CHANNELS)
        else $error("scan pointer out of range");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= WORDS_PER_FRAME)
        else $error("word count beyond frame size");

    a_enc_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.vld |-> (r_state == ST_ENC_WAIT))
        else $error("encoder result outside of wait state");

    a_fade_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> (r_fade >= $past(r_fade)))
        else $error("fade counter went down");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && w_load && n_out_last) |=>
            ((r_state == ST_IDLE) && o_out_valid && o_last_byte))
        else $error("frame end did not return to idle");

endmodule
